// File: src/block_match_tolerance_test_core_assert.svh
// Assertion macros used by the block match tolerance test controller.
`ifndef BLOCK_MATCH_TOLERANCE_TEST_CORE_ASSERT_SVH
`define BLOCK_MATCH_TOLERANCE_TEST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define BMTT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define BMTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bmtt_pkg.sv
// Package with the shared types and constants of the block match tolerance test.
`default_nettype none

package bmtt_pkg;

   localparam int PIXEL_W     = 8;
   localparam int SQ_W        = 16;
   localparam int TOL_W       = 36;
   localparam int MODE_W      = 2;
   localparam int METRIC_W    = 26;
   localparam int COUNT_W     = 11;
   localparam int SCALE_W     = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;

   localparam longint MAX_PIXEL = 255;
   localparam longint MAX_SQ    = 65025;

   // Metric selection codes.
   localparam logic [MODE_W-1:0] MODE_MSE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TSE = 2'd2;

   // Tolerance scale codes.
   localparam logic [SCALE_W-1:0] SCALE_0P4 = 2'd0;
   localparam logic [SCALE_W-1:0] SCALE_0P6 = 2'd1;
   localparam logic [SCALE_W-1:0] SCALE_1P0 = 2'd2;

   // Register select, taken from address bit 3 (registers are 8 bytes apart).
   localparam logic REG_MODE = 1'b0;
   localparam logic REG_TOL  = 1'b1;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_MUL,
      ST_VAR,
      ST_SCALE,
      ST_DECIDE
   } bmtt_state_type;

   typedef struct packed {
      logic accum;
      logic mul_init;
      logic mul_step;
      logic var_en;
      logic scale_en;
      logic out_load;
   } bmtt_cmd_type;

   typedef struct packed {
      logic block_end;
   } bmtt_status_type;

endpackage

`default_nettype wire

// File: src/bmtt_channel_if.sv
// Valid/ready channel interfaces for pixel pair items and result items.
`default_nettype none

interface bmtt_req_if;
   logic                         valid;
   logic                         ready;
   logic [bmtt_pkg::PIXEL_W-1:0] image_pixel;
   logic [bmtt_pkg::PIXEL_W-1:0] dict_pixel;
   logic                         last_pair;

   modport source (output valid, output image_pixel, output dict_pixel,
                   output last_pair, input ready);
   modport sink   (input valid, input image_pixel, input dict_pixel,
                   input last_pair, output ready);
endinterface

interface bmtt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          is_match;
   logic [bmtt_pkg::METRIC_W-1:0] metric_value;
   logic [bmtt_pkg::COUNT_W-1:0]  pixel_count;
   logic [bmtt_pkg::SCALE_W-1:0]  scale_code;

   modport source (output valid, output is_match, output metric_value,
                   output pixel_count, output scale_code, input ready);
   modport sink   (input valid, input is_match, input metric_value,
                   input pixel_count, input scale_code, output ready);
endinterface

`default_nettype wire

// File: src/bmtt_csr.sv
// Configuration registers behind an APB-style write and read port.
`default_nettype none

module bmtt_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [bmtt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [bmtt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [bmtt_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output logic      [bmtt_pkg::MODE_W-1:0]       metric_mode,
   output logic      [bmtt_pkg::TOL_W-1:0]        tolerance_q8
);

   logic [bmtt_pkg::MODE_W-1:0] mode_ff;
   logic [bmtt_pkg::TOL_W-1:0]  tol_ff;
   logic                        write_en;
   logic                        reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         tol_ff  <= '0;
      end else if (write_en) begin
         if (reg_sel == bmtt_pkg::REG_MODE) begin
            mode_ff <= csr_pwdata[bmtt_pkg::MODE_W-1:0];
         end else begin
            tol_ff <= csr_pwdata[bmtt_pkg::TOL_W-1:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == bmtt_pkg::REG_TOL) begin
         csr_prdata = bmtt_pkg::CSR_DATA_W'(tol_ff);
      end else begin
         csr_prdata = bmtt_pkg::CSR_DATA_W'(mode_ff);
      end
   end

   assign metric_mode  = mode_ff;
   assign tolerance_q8 = tol_ff;

endmodule

`default_nettype wire

// File: src/bmtt_datapath.sv
// Accumulators, serial products, scale and match decision, and result register.
`default_nettype none

module bmtt_datapath #(
   parameter int MAX_BLOCK_PIXELS = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bmtt_pkg::bmtt_cmd_type          cmd,
   output bmtt_pkg::bmtt_status_type            status,
   input  wire logic [bmtt_pkg::PIXEL_W-1:0]    image_pixel,
   input  wire logic [bmtt_pkg::PIXEL_W-1:0]    dict_pixel,
   input  wire logic                            last_pair,
   input  wire logic [bmtt_pkg::MODE_W-1:0]     metric_mode,
   input  wire logic [bmtt_pkg::TOL_W-1:0]      tolerance_q8,
   output logic                                 is_match,
   output logic      [bmtt_pkg::METRIC_W-1:0]   metric_value,
   output logic      [bmtt_pkg::COUNT_W-1:0]    pixel_count,
   output logic      [bmtt_pkg::SCALE_W-1:0]    scale_code
);

   localparam int CW   = $clog2(MAX_BLOCK_PIXELS + 1);
   localparam int SW   = $clog2(longint'(MAX_BLOCK_PIXELS) * bmtt_pkg::MAX_SQ + 1);
   localparam int PW   = $clog2(longint'(MAX_BLOCK_PIXELS) * bmtt_pkg::MAX_PIXEL + 1);
   localparam int QW   = SW;
   localparam int NQW  = CW + QW;
   localparam int NPW  = CW + PW;
   localparam int NTW  = CW + bmtt_pkg::TOL_W;
   localparam int PPW  = 2 * PW;
   localparam int VW   = (NQW > PPW) ? NQW : PPW;
   localparam int SCW  = (VW + 5 > NPW) ? VW + 5 : NPW;
   localparam int LHW  = SW + 12;
   localparam int RHW  = NTW + 4;
   localparam int CPW  = (LHW > RHW) ? LHW : RHW;
   localparam int MXW  = (SW > bmtt_pkg::METRIC_W) ? SW : bmtt_pkg::METRIC_W;
   localparam int NXW  = (CW > bmtt_pkg::COUNT_W) ? CW : bmtt_pkg::COUNT_W;
   localparam logic [CW-1:0] MaxCount = CW'(MAX_BLOCK_PIXELS);

   // Block accumulators.
   logic [SW-1:0]                sq_sum_ff, sq_sum_in;
   logic [bmtt_pkg::SQ_W-1:0]    sq_max_ff, sq_max_in;
   logic [PW-1:0]                pix_sum_ff, pix_sum_in;
   logic [QW-1:0]                pix_sq_ff, pix_sq_in;
   logic [CW-1:0]                count_ff, count_in;

   // Serial products by the pair count, most significant bit first.
   logic [CW-1:0]                n_shift_ff;
   logic [NQW-1:0]               nq_ff;
   logic [NPW-1:0]               np_ff;
   logic [NTW-1:0]               nt_ff;
   logic [PPW-1:0]               pp_ff;
   logic [VW-1:0]                var_ff;
   logic [bmtt_pkg::SCALE_W-1:0] scale_ff, scale_in;

   // Result register.
   logic                         match_ff, match_in;
   logic [bmtt_pkg::METRIC_W-1:0] metric_ff;
   logic [bmtt_pkg::COUNT_W-1:0] count_out_ff;
   logic [bmtt_pkg::SCALE_W-1:0] scale_out_ff;

   logic [bmtt_pkg::PIXEL_W-1:0] diff;
   logic [bmtt_pkg::SQ_W-1:0]    diff_sq;
   logic [bmtt_pkg::SQ_W-1:0]    img_sq;
   logic                         n_bit;
   logic [VW-1:0]                nq_wide, pp_wide;
   logic [SCW-1:0]               var20, var10, np_wide;
   logic [SW-1:0]                metric_full;
   logic [LHW-1:0]               metric_lhw;
   logic [CPW-1:0]               lhs, base, rhs;
   logic [MXW-1:0]               metric_ext;
   logic [NXW-1:0]               count_ext;

   always_comb begin
      diff      = (image_pixel >= dict_pixel) ? image_pixel - dict_pixel
                                              : dict_pixel - image_pixel;
      diff_sq   = bmtt_pkg::SQ_W'(diff) * bmtt_pkg::SQ_W'(diff);
      img_sq    = bmtt_pkg::SQ_W'(image_pixel) * bmtt_pkg::SQ_W'(image_pixel);
      sq_sum_in = sq_sum_ff + SW'(diff_sq);
      sq_max_in = (diff_sq > sq_max_ff) ? diff_sq : sq_max_ff;
      pix_sum_in = pix_sum_ff + PW'(image_pixel);
      pix_sq_in = pix_sq_ff + QW'(img_sq);
      count_in  = count_ff + CW'(1);
      status.block_end = last_pair || (count_in == MaxCount);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_sum_ff  <= '0;
         sq_max_ff  <= '0;
         pix_sum_ff <= '0;
         pix_sq_ff  <= '0;
         count_ff   <= '0;
      end else if (cmd.out_load) begin
         sq_sum_ff  <= '0;
         sq_max_ff  <= '0;
         pix_sum_ff <= '0;
         pix_sq_ff  <= '0;
         count_ff   <= '0;
      end else if (cmd.accum) begin
         sq_sum_ff  <= sq_sum_in;
         sq_max_ff  <= sq_max_in;
         pix_sum_ff <= pix_sum_in;
         pix_sq_ff  <= pix_sq_in;
         count_ff   <= count_in;
      end
   end

   assign n_bit = n_shift_ff[CW-1];

   always_ff @(posedge clock) begin
      if (cmd.mul_init) begin
         n_shift_ff <= count_in;
         nq_ff      <= '0;
         np_ff      <= '0;
         nt_ff      <= '0;
      end else if (cmd.mul_step) begin
         n_shift_ff <= n_shift_ff << 1;
         nq_ff      <= (nq_ff << 1) + (n_bit ? NQW'(pix_sq_ff) : '0);
         np_ff      <= (np_ff << 1) + (n_bit ? NPW'(pix_sum_ff) : '0);
         nt_ff      <= (nt_ff << 1) + (n_bit ? NTW'(tolerance_q8) : '0);
         pp_ff      <= PPW'(pix_sum_ff) * PPW'(pix_sum_ff);
      end
   end

   // Variance numerator n*Q - P*P, clamped at zero.
   always_comb begin
      nq_wide = VW'(nq_ff);
      pp_wide = VW'(pp_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.var_en) begin
         var_ff <= (nq_wide >= pp_wide) ? nq_wide - pp_wide : '0;
      end
   end

   // Ratio tests against 0.05 and 0.1, cross-multiplied by the mean numerator.
   always_comb begin
      var20   = (SCW'(var_ff) << 4) + (SCW'(var_ff) << 2);
      var10   = (SCW'(var_ff) << 3) + (SCW'(var_ff) << 1);
      np_wide = SCW'(np_ff);
      priority if (pix_sum_ff == '0) begin
         scale_in = bmtt_pkg::SCALE_1P0;
      end else if (var20 <= np_wide) begin
         scale_in = bmtt_pkg::SCALE_0P4;
      end else if (var10 <= np_wide) begin
         scale_in = bmtt_pkg::SCALE_0P6;
      end else begin
         scale_in = bmtt_pkg::SCALE_1P0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale_en) begin
         scale_ff <= scale_in;
      end
   end

   // Match test: 2560 * metric against k * tolerance (times n for the mean).
   always_comb begin
      metric_full = (metric_mode == bmtt_pkg::MODE_MAX) ? SW'(sq_max_ff) : sq_sum_ff;
      metric_lhw  = (LHW'(metric_full) << 11) + (LHW'(metric_full) << 9);
      lhs         = CPW'(metric_lhw);
      base        = (metric_mode == bmtt_pkg::MODE_MSE) ? CPW'(nt_ff)
                                                        : CPW'(tolerance_q8);
      unique case (scale_ff)
         bmtt_pkg::SCALE_0P4: rhs = base << 2;
         bmtt_pkg::SCALE_0P6: rhs = (base << 2) + (base << 1);
         default:             rhs = (base << 3) + (base << 1);
      endcase
      match_in   = (lhs <= rhs);
      metric_ext = MXW'(metric_full);
      count_ext  = NXW'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         match_ff     <= match_in;
         metric_ff    <= metric_ext[bmtt_pkg::METRIC_W-1:0];
         count_out_ff <= count_ext[bmtt_pkg::COUNT_W-1:0];
         scale_out_ff <= scale_ff;
      end
   end

   assign is_match     = match_ff;
   assign metric_value = metric_ff;
   assign pixel_count  = count_out_ff;
   assign scale_code   = scale_out_ff;

endmodule

`default_nettype wire

// File: src/bmtt_ctrl.sv
// Controller state machine that sequences accumulation and the end-of-block decision.
`default_nettype none

`include "block_match_tolerance_test_core_assert.svh"

module bmtt_ctrl #(
   parameter int MAX_BLOCK_PIXELS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire bmtt_pkg::bmtt_status_type   status,
   output bmtt_pkg::bmtt_cmd_type           cmd
);

   localparam int CW  = $clog2(MAX_BLOCK_PIXELS + 1);
   localparam int STW = $clog2(CW + 1);
   localparam logic [STW-1:0] LastStep = STW'(CW - 1);

   bmtt_pkg::bmtt_state_type state_ff, state_in;
   logic [STW-1:0]           step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_fire;
   logic                     out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmtt_pkg::ST_ACCUM;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         bmtt_pkg::ST_ACCUM: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (status.block_end) begin
                  cmd.mul_init = 1'b1;
                  step_in      = '0;
                  state_in     = bmtt_pkg::ST_MUL;
               end
            end
         end
         bmtt_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff + STW'(1);
            if (step_ff == LastStep) begin
               state_in = bmtt_pkg::ST_VAR;
            end
         end
         bmtt_pkg::ST_VAR: begin
            cmd.var_en = 1'b1;
            state_in   = bmtt_pkg::ST_SCALE;
         end
         bmtt_pkg::ST_SCALE: begin
            cmd.scale_en = 1'b1;
            state_in     = bmtt_pkg::ST_DECIDE;
         end
         bmtt_pkg::ST_DECIDE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = bmtt_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = bmtt_pkg::ST_ACCUM;
         end
      endcase
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BMTT_ASSERT_NEXT(a_end_starts_mul, req_fire && status.block_end, state_ff == bmtt_pkg::ST_MUL, "block end did not start the products")
   `BMTT_ASSERT_NOW(a_load_when_free, cmd.out_load, !rsp_valid_ff || rsp_ready, "result overwritten before it was taken")
   `BMTT_ASSERT_NEXT(a_load_shows_rsp, cmd.out_load, rsp_valid_ff && state_ff == bmtt_pkg::ST_ACCUM, "result load did not raise valid")
   `BMTT_ASSERT_NOW(a_step_bound, state_ff == bmtt_pkg::ST_MUL, step_ff <= LastStep, "product step counter overran")

endmodule

`default_nettype wire

// File: src/block_match_tolerance_test_core.sv
// Top level of the block match tolerance test: configuration, control and datapath.
// Throughput: one pixel pair a cycle inside a block; after the last pair the input
// stalls while the end-of-block sequence runs, and longer while a result item waits.
// Result: after the last pair is accepted, the controller runs the serial multiply by
// the pair count (one bit a cycle), then the variance, scale and decision steps.
// Reset: synchronous, active high; clears accumulators, configuration registers, state and valid.
`default_nettype none

module block_match_tolerance_test_core #(
   parameter int MAX_BLOCK_PIXELS = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bmtt_req_if.sink                               req_if,
   bmtt_rsp_if.source                             rsp_if,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [bmtt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [bmtt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [bmtt_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   // The metric mode sits at byte address 0 and the tolerance at byte address 8.
   // Only address bit 3 selects the register, so other addresses alias those two.
   logic [bmtt_pkg::MODE_W-1:0] metric_mode;
   logic [bmtt_pkg::TOL_W-1:0]  tolerance_q8;

   bmtt_pkg::bmtt_cmd_type      cmd;
   bmtt_pkg::bmtt_status_type   status;

   bmtt_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .metric_mode  (metric_mode),
      .tolerance_q8 (tolerance_q8)
   );

   // The controller takes items while accumulating, then walks the end-of-block
   // sequence: serial products by the pair count, variance numerator, scale choice,
   // and the match decision, which loads the result register once it is free.
   // A finished result waits in that register while the next block streams in.
   bmtt_ctrl #(
      .MAX_BLOCK_PIXELS (MAX_BLOCK_PIXELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the block sums, the products, the scale and the result item.
   // A block also ends when its pair count reaches MAX_BLOCK_PIXELS.
   bmtt_datapath #(
      .MAX_BLOCK_PIXELS (MAX_BLOCK_PIXELS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .image_pixel  (req_if.image_pixel),
      .dict_pixel   (req_if.dict_pixel),
      .last_pair    (req_if.last_pair),
      .metric_mode  (metric_mode),
      .tolerance_q8 (tolerance_q8),
      .is_match     (rsp_if.is_match),
      .metric_value (rsp_if.metric_value),
      .pixel_count  (rsp_if.pixel_count),
      .scale_code   (rsp_if.scale_code)
   );

endmodule

`default_nettype wire

// File: tb/block_match_tolerance_test_core_tb.sv
// Self-checking testbench for the block match tolerance test core.
`timescale 1ns / 100ps

module block_match_tolerance_test_core_tb;

   // The core under test is built for blocks of up to 1024 pixel pairs.
   localparam int MAX_BLOCK = 1024;

   // The drain wait, used before any register write and at the end of the run, is longer
   // than the result latency of the core; CW is the width of the pair count.
   localparam int CW             = $clog2(MAX_BLOCK + 1);
   localparam int RESULT_LATENCY = CW + 3;
   localparam int DRAIN_CYCLES   = RESULT_LATENCY + 8;

   // A correct run never goes longer than the receiver's long hold plus one block
   // turnaround without an item moving, so this limit leaves a wide margin.
   localparam int STALL_LIMIT      = 4000;
   localparam int LONG_HOLD_CYCLES = 300;

   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 56;

   localparam int PIXEL_MAX = int'(bmtt_pkg::MAX_PIXEL);

   // The match test compares metric * 256 * 10 against weight * tolerance_q8 (and n
   // for the mean), where the weight is ten times the tolerance scale (4, 6 or 10).
   localparam longint unsigned TOL_UNIT = 2560;

   // Metric code three is not assigned; the core treats it as total squared error.
   localparam logic [bmtt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [bmtt_pkg::PIXEL_W-1:0] image_pixel;
      logic [bmtt_pkg::PIXEL_W-1:0] dict_pixel;
      logic                         last_pair;
   } pixel_pair_type;

   typedef struct packed {
      logic                          is_match;
      logic [bmtt_pkg::METRIC_W-1:0] metric_value;
      logic [bmtt_pkg::COUNT_W-1:0]  pixel_count;
      logic [bmtt_pkg::SCALE_W-1:0]  scale_code;
   } match_result_type;

   logic clock = 1'b0;
   logic reset;

   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [bmtt_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bmtt_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bmtt_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   bmtt_req_if pair_bus ();
   bmtt_rsp_if result_bus ();

   // Pixel pairs waiting to be offered, and results that the core still owes.
   pixel_pair_type   pending_pairs[$];
   match_result_type expected_results[$];
   pixel_pair_type   next_pair;
   logic             pair_taken;

   // Idle rates in percent for the sender and the receiver; set per phase.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // Long receiver hold-off, requested by the stimulus and timed by its own process.
   logic long_hold_go = 1'b0;
   logic rsp_hold = 1'b0;

   int mismatch_count = 0;
   int idle_cycles = 0;
   int stim_count = 0;
   int open_block_len = 0;

   // Register copies and block accumulators of the prediction.
   logic [bmtt_pkg::MODE_W-1:0] cfg_mode = bmtt_pkg::MODE_MSE;
   logic [bmtt_pkg::TOL_W-1:0]  cfg_tol = '0;
   longint unsigned   sq_err_total = 0;
   longint unsigned   sq_err_peak = 0;
   longint unsigned   img_sum = 0;
   longint unsigned   img_sq_sum = 0;
   longint unsigned   pairs_seen = 0;

   block_match_tolerance_test_core #(
      .MAX_BLOCK_PIXELS(MAX_BLOCK)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_if     (pair_bus),
      .rsp_if     (result_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Prints one line per mismatch and counts it; the run goes on afterwards.
   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Folds one accepted pixel pair into the block statistics. On the last pair of a
   // block, or when the block reaches its largest size, it works out the tolerance
   // scale from the variance over mean of the image pixels, forms the metric chosen
   // by the mode register and queues the result that the core must produce.
   task automatic accumulate_pair(input logic [bmtt_pkg::PIXEL_W-1:0] image_pixel,
                                  input logic [bmtt_pkg::PIXEL_W-1:0] dict_pixel,
                                  input logic last_pair);
      longint unsigned img, dic, diff, sq, n, nq, pp, var_num, mean_num;
      longint unsigned weight, metric, lhs, rhs;
      logic [bmtt_pkg::SCALE_W-1:0] scale;
      match_result_type res;
      img = 64'(image_pixel);
      dic = 64'(dict_pixel);
      diff = img >= dic ? img - dic : dic - img;
      sq = diff * diff;
      sq_err_total += sq;
      if (sq > sq_err_peak) sq_err_peak = sq;
      img_sum += img;
      img_sq_sum += img * img;
      pairs_seen += 1;
      if (last_pair || pairs_seen >= MAX_BLOCK) begin
         n = pairs_seen;
         // An all-zero image block has no defined ratio and keeps the full tolerance.
         if (img_sum == 0) begin
            scale = bmtt_pkg::SCALE_1P0;
         end else begin
            // Ratio var/mean = (n*Q - P*P) / (n*P); compared against 1/20 and 1/10.
            nq = n * img_sq_sum;
            pp = img_sum * img_sum;
            var_num = nq >= pp ? nq - pp : 0;
            mean_num = n * img_sum;
            if (20 * var_num <= mean_num) scale = bmtt_pkg::SCALE_0P4;
            else if (10 * var_num <= mean_num) scale = bmtt_pkg::SCALE_0P6;
            else scale = bmtt_pkg::SCALE_1P0;
         end
         case (scale)
            bmtt_pkg::SCALE_0P4: weight = 4;
            bmtt_pkg::SCALE_0P6: weight = 6;
            default:             weight = 10;
         endcase
         case (cfg_mode)
            bmtt_pkg::MODE_MAX: begin
               metric = sq_err_peak;
               rhs = weight * cfg_tol;
            end
            bmtt_pkg::MODE_MSE: begin
               // The mean is compared without dividing: the pair count moves right.
               metric = sq_err_total;
               rhs = weight * n * cfg_tol;
            end
            default: begin
               metric = sq_err_total;
               rhs = weight * cfg_tol;
            end
         endcase
         lhs = TOL_UNIT * metric;
         res.is_match = lhs <= rhs;
         res.metric_value = metric[bmtt_pkg::METRIC_W-1:0];
         res.pixel_count = n[bmtt_pkg::COUNT_W-1:0];
         res.scale_code = scale;
         expected_results.push_back(res);
         sq_err_total = 0;
         sq_err_peak = 0;
         img_sum = 0;
         img_sq_sum = 0;
         pairs_seen = 0;
      end
   endtask

   // Input driver: a new item is put up at the falling edge once the previous one
   // was taken, or the bus was empty, unless the sender decides to idle.
   always @(negedge clock) begin
      if (reset) begin
         pair_bus.valid <= 1'b0;
      end else if (!pair_bus.valid || pair_taken) begin
         if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_pair = pending_pairs.pop_front();
            pair_bus.valid       <= 1'b1;
            pair_bus.image_pixel <= next_pair.image_pixel;
            pair_bus.dict_pixel  <= next_pair.dict_pixel;
            pair_bus.last_pair   <= next_pair.last_pair;
         end else begin
            pair_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver: stalls at the configured rate, and holds off entirely while
   // the long hold is running.
   always @(negedge clock) begin
      if (reset) begin
         result_bus.ready <= 1'b0;
      end else begin
         result_bus.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Monitor: at every rising edge, an accepted pixel pair feeds the prediction and
   // an accepted result is compared field by field with the oldest expectation.
   always @(posedge clock) begin
      match_result_type want;
      if (reset) begin
         pair_taken <= 1'b0;
      end else begin
         pair_taken <= pair_bus.valid && pair_bus.ready;
         if (pair_bus.valid && pair_bus.ready) begin
            accumulate_pair(pair_bus.image_pixel, pair_bus.dict_pixel, pair_bus.last_pair);
         end
         if (result_bus.valid && result_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result item, metric_value",
                               64'(result_bus.metric_value), 0);
            end else begin
               want = expected_results.pop_front();
               if (result_bus.is_match !== want.is_match)
                  report_mismatch("is_match", 64'(result_bus.is_match),
                                  64'(want.is_match));
               if (result_bus.metric_value !== want.metric_value)
                  report_mismatch("metric_value", 64'(result_bus.metric_value),
                                  64'(want.metric_value));
               if (result_bus.pixel_count !== want.pixel_count)
                  report_mismatch("pixel_count", 64'(result_bus.pixel_count),
                                  64'(want.pixel_count));
               if (result_bus.scale_code !== want.scale_code)
                  report_mismatch("scale_code", 64'(result_bus.scale_code),
                                  64'(want.scale_code));
            end
         end
      end
   end

   // Watchdog: counts cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((pair_bus.valid && pair_bus.ready) ||
                   (result_bus.valid && result_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Long receiver hold-off. While it runs the sender keeps offering pairs, so the
   // core fills its result stage and has to stall its input.
   initial begin
      wait (long_hold_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // APB write: setup cycle, then access cycle until pready; the prediction takes
   // the masked value at the same time, since writes only happen while idle.
   task automatic csr_write(input logic reg_sel,
                            input logic [bmtt_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == bmtt_pkg::REG_MODE) cfg_mode = value[bmtt_pkg::MODE_W-1:0];
      else cfg_tol = value[bmtt_pkg::TOL_W-1:0];
   endtask

   // Queues one pixel pair and keeps track of how long the open block has grown,
   // so that a phase can always be closed on a block boundary.
   task automatic queue_pair(input int img, input int dic, input bit last);
      pixel_pair_type pair;
      pair.image_pixel = img[bmtt_pkg::PIXEL_W-1:0];
      pair.dict_pixel = dic[bmtt_pkg::PIXEL_W-1:0];
      pair.last_pair = last;
      pending_pairs.push_back(pair);
      stim_count++;
      if (last || open_block_len + 1 >= MAX_BLOCK) open_block_len = 0;
      else open_block_len++;
   endtask

   function automatic int clamp_pixel(input int v);
      return v < 0 ? 0 : (v > PIXEL_MAX ? PIXEL_MAX : v);
   endfunction

   // Queues a well-formed block. The image is all zero, fully random, or a level
   // with a little noise (so that all three tolerance scales come up); the
   // dictionary block is either random or the image with a little noise.
   task automatic queue_block(input int pairs, input bit close_block);
      int style, base, spread, dict_noise, img, dic, i;
      bit random_dict;
      style = $urandom_range(0, 9);
      base = $urandom_range(0, PIXEL_MAX);
      spread = $urandom_range(0, 6);
      dict_noise = $urandom_range(0, 8);
      random_dict = $urandom_range(0, 3) == 0;
      for (i = 0; i < pairs; i++) begin
         case (style)
            0:       img = 0;
            1, 2:    img = $urandom_range(0, PIXEL_MAX);
            default: img = clamp_pixel(base + int'($urandom_range(0, 2 * spread)) - spread);
         endcase
         if (random_dict) dic = $urandom_range(0, PIXEL_MAX);
         else dic = clamp_pixel(img + int'($urandom_range(0, 2 * dict_noise)) - dict_noise);
         queue_pair(img, dic, close_block && i == pairs - 1);
      end
   endtask

   // Unstructured pairs with the last flag set at random.
   task automatic queue_noise(input int count);
      int i;
      for (i = 0; i < count; i++)
         queue_pair($urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX),
                    $urandom_range(0, 7) == 0);
   endtask

   // Waits until every queued pair has been taken and every result has arrived,
   // then lets the core settle before anything else happens.
   task automatic wait_until_idle();
      while (pending_pairs.size() != 0 || pair_bus.valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int phase;
      bit paused;
      logic [bmtt_pkg::TOL_W-1:0]      tol_value;
      logic [bmtt_pkg::MODE_W-1:0]     mode_value;
      logic [bmtt_pkg::CSR_DATA_W-1:0] junk;
      logic [63:0]                     wide_rand;

      reset = 1'b1;
      pair_bus.valid = 1'b0;
      pair_bus.image_pixel = '0;
      pair_bus.dict_pixel = '0;
      pair_bus.last_pair = 1'b0;
      result_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset registers (mean squared error, zero tolerance) only a zero
      // metric matches; one single-pair block checks that.
      queue_pair(0, 0, 1'b1);
      wait_until_idle();

      // Directed blocks. A tolerance of 2.5 puts a single pair with difference one
      // exactly on the match boundary; difference two falls just outside it.
      csr_write(bmtt_pkg::REG_MODE,
                {{(bmtt_pkg::CSR_DATA_W - bmtt_pkg::MODE_W){1'b0}}, bmtt_pkg::MODE_MSE});
      csr_write(bmtt_pkg::REG_TOL, 64'd640);
      queue_pair(11, 10, 1'b1);
      queue_pair(12, 10, 1'b1);
      // Largest differences in both directions, and equal extreme pixels.
      queue_pair(255, 0, 1'b1);
      queue_pair(0, 255, 1'b1);
      queue_pair(255, 255, 1'b1);
      // All-zero image block: the ratio is undefined and the full tolerance is used.
      queue_pair(0, 0, 1'b0);
      queue_pair(0, 200, 1'b0);
      queue_pair(0, 17, 1'b0);
      queue_pair(0, 255, 1'b1);
      // Flat image block: no variance, the tolerance is scaled by 0.4.
      queue_pair(200, 198, 1'b0);
      queue_pair(200, 201, 1'b0);
      queue_pair(200, 200, 1'b1);
      // Image pixels 3 and 4 give a ratio of 1/14, which selects the 0.6 scale.
      queue_pair(3, 3, 1'b0);
      queue_pair(4, 6, 1'b1);
      // Image pixels 0 and 255 give a large ratio and the full tolerance.
      queue_pair(0, 10, 1'b0);
      queue_pair(255, 250, 1'b1);
      wait_until_idle();

      // Random phases. Each one sets both registers (sometimes with junk above the
      // register width), picks the idle rates and streams mostly well-formed blocks
      // with a sprinkling of unstructured pairs. Every phase ends on a block boundary
      // and drains completely before the registers change again.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0:       mode_value = bmtt_pkg::MODE_MSE;
            1:       mode_value = bmtt_pkg::MODE_MAX;
            2:       mode_value = bmtt_pkg::MODE_TSE;
            default: mode_value = MODE_UNUSED;
         endcase
         wide_rand = {$urandom, $urandom};
         case (phase % 5)
            0:       tol_value = '0;
            1:       tol_value = '1;
            2:       tol_value = wide_rand[bmtt_pkg::TOL_W-1:0];
            default: tol_value = bmtt_pkg::TOL_W'($urandom_range(0, 64000));
         endcase
         junk = (phase % 2 == 1) ? {$urandom, $urandom} : '0;
         csr_write(bmtt_pkg::REG_MODE,
                   {junk[bmtt_pkg::CSR_DATA_W-1:bmtt_pkg::MODE_W], mode_value});
         csr_write(bmtt_pkg::REG_TOL,
                   {junk[bmtt_pkg::CSR_DATA_W-1:bmtt_pkg::TOL_W], tol_value});

         case (phase % 5)
            1: begin
               send_idle_pct = 80;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 80;
            end
            3: begin
               send_idle_pct = 24;
               recv_stall_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase

         // Back pressure: the receiver holds off for a long stretch while the
         // sender keeps going at full rate.
         if (phase == 4) long_hold_go = 1'b1;

         stim_count = 0;
         paused = 1'b0;
         while (stim_count < PHASE_ITEMS) begin
            // Once, halfway through phase five and inside an open block, the sender
            // stops until every result so far has come back.
            if (phase == 5 && !paused && stim_count >= PHASE_ITEMS / 2) begin
               queue_block($urandom_range(1, 6), 1'b0);
               wait_until_idle();
               paused = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) queue_noise($urandom_range(4, 12));
            else if ($urandom_range(0, 9) == 0) queue_block($urandom_range(13, 64), 1'b1);
            else queue_block($urandom_range(1, 12), 1'b1);
         end
         if (open_block_len != 0)
            queue_pair($urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX), 1'b1);

         wait_until_idle();
      end

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
